### sv/md5sh_pkg.sv
`timescale 1ns / 1ps
// md5sh_pkg: shared types, initial chaining values and round tables for the MD5 hasher.
package md5sh_pkg;

   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
      logic [31:0] d;
   } abcd_type;

   localparam logic [31:0] INIT_A = 32'h67452301;
   localparam logic [31:0] INIT_B = 32'hEFCDAB89;
   localparam logic [31:0] INIT_C = 32'h98BADCFE;
   localparam logic [31:0] INIT_D = 32'h10325476;

   localparam logic [7:0] PAD_BYTE = 8'h80;

   // Additive round constant for round r.
   function automatic logic [31:0] round_const(input logic [5:0] r);
      logic [31:0] k;
      begin
         case (r)
            6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;  default: k = 32'heb86d391;
         endcase
         return k;
      end
   endfunction

   // Message word used by round r.
   function automatic logic [3:0] msg_index(input logic [5:0] r);
      logic [3:0] lo;
      logic [3:0] g;
      begin
         lo = r[3:0];
         case (r[5:4])
            2'd0:    g = lo;
            2'd1:    g = 4'(lo * 4'd5 + 4'd1);
            2'd2:    g = 4'(lo * 4'd3 + 4'd5);
            default: g = 4'(lo * 4'd7);
         endcase
         return g;
      end
   endfunction

   // Left rotate amount for round r.
   function automatic logic [4:0] rot_amount(input logic [5:0] r);
      logic [4:0] s;
      begin
         case ({r[5:4], r[1:0]})
            4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
            4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  default: s = 5'd21;
         endcase
         return s;
      end
   endfunction

endpackage

### sv/md5sh_round.sv
`timescale 1ns / 1ps
// md5sh_round: one MD5 round step, reused for all 64 rounds of a block.
module md5sh_round (
   input  logic [5:0]           rnd,
   input  md5sh_pkg::abcd_type  cur,
   input  logic [31:0]          km,    // K[rnd] + M[g(rnd)], precomputed
   output md5sh_pkg::abcd_type  nxt
);
   import md5sh_pkg::*;

   logic [31:0] f;
   logic [31:0] t;
   logic [63:0] rot_wide;
   logic [4:0]  s;

   always_comb begin
      case (rnd[5:4])
         2'd0:    f = (cur.b & cur.c) | (~cur.b & cur.d);
         2'd1:    f = (cur.d & cur.b) | (~cur.d & cur.c);
         2'd2:    f = cur.b ^ cur.c ^ cur.d;
         default: f = cur.c ^ (cur.b | ~cur.d);
      endcase
   end

   assign t        = f + cur.a + km;
   assign s        = rot_amount(rnd);
   assign rot_wide = {t, t} << s;

   assign nxt.a = cur.d;
   assign nxt.d = cur.c;
   assign nxt.c = cur.b;
   assign nxt.b = cur.b + rot_wide[63:32];

endmodule

### sv/md5_stream_hasher_top.sv
`timescale 1ns / 1ps
// md5_stream_hasher_top: byte-serial MD5 engine with padding and digest output.
//
// Message bytes come in one per request transaction and are packed little-endian
// into a 16-word block buffer; an ordinary byte leaves req_ready high for the next
// request. The 64th byte of a block starts a compression: a load step, the 64
// rounds through the single shared round unit (one round per cycle), and a step to
// fold the working words into the chain, with req_ready low throughout. On
// end_of_message the engine appends 0x80 and, if it fits, the bit length in a pad
// step, runs one compression (two when 8 or fewer bytes of the block were left, a
// length step writing the length into the fresh block), then presents the digest
// as four response transactions A, B, C, D (word_index 0..3, last_word on D).
// After D is taken the engine is back in its reset state for the next message.
// A request with byte_present low and end_of_message low is a no-op.
module md5_stream_hasher_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_present,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_digest_word,
   output logic [1:0]  rsp_word_index,
   output logic        rsp_last_word
);
   import md5sh_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_PAD, S_LEN, S_LOAD, S_ROUND, S_ADD, S_OUT
   } state_type;

   // where to go once a compression has been folded in
   typedef enum logic [1:0] {
      NXT_IDLE, NXT_PAD, NXT_LEN, NXT_OUT
   } after_type;

   state_type   state_ff, state_in;
   after_type   after_ff, after_in;
   abcd_type    chain_ff, chain_in;
   abcd_type    work_ff, work_in;
   abcd_type    round_out;
   logic [31:0] buf_ff [16];
   logic [31:0] buf_in [16];
   logic [63:0] len_ff, len_in;
   logic [31:0] km_ff, km_in;
   logic [5:0]  rnd_ff, rnd_in;
   logic [1:0]  idx_ff, idx_in;
   logic [5:0]  pos;
   logic [5:0]  rnd_next;

   assign pos      = len_ff[8:3];
   assign rnd_next = rnd_ff + 6'd1;

   md5sh_round u_round (
      .rnd (rnd_ff),
      .cur (work_ff),
      .km  (km_ff),
      .nxt (round_out)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);

   always_comb begin
      case (idx_ff)
         2'd0:    rsp_digest_word = chain_ff.a;
         2'd1:    rsp_digest_word = chain_ff.b;
         2'd2:    rsp_digest_word = chain_ff.c;
         default: rsp_digest_word = chain_ff.d;
      endcase
   end
   assign rsp_word_index = idx_ff;
   assign rsp_last_word  = (idx_ff == 2'd3);

   always_comb begin
      state_in = state_ff;
      after_in = after_ff;
      chain_in = chain_ff;
      work_in  = work_ff;
      buf_in   = buf_ff;
      len_in   = len_ff;
      km_in    = km_ff;
      rnd_in   = rnd_ff;
      idx_in   = idx_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_byte_present) begin
                  buf_in[pos[5:2]][{pos[1:0], 3'b000} +: 8] = req_data_byte;
                  len_in = len_ff + 64'd8;
                  if (pos == 6'd63) begin
                     // block full: compress, then pad if the message ends here
                     state_in = S_LOAD;
                     after_in = req_end_of_message ? NXT_PAD : NXT_IDLE;
                  end else if (req_end_of_message) begin
                     state_in = S_PAD;
                  end
               end else if (req_end_of_message) begin
                  state_in = S_PAD;
               end
            end
         end
         S_PAD: begin
            buf_in[pos[5:2]][{pos[1:0], 3'b000} +: 8] = PAD_BYTE;
            state_in = S_LOAD;
            if (pos >= 6'd56) begin
               // no room for the length: it goes in an extra block
               after_in = NXT_LEN;
            end else begin
               buf_in[14] = len_ff[31:0];
               buf_in[15] = len_ff[63:32];
               after_in   = NXT_OUT;
            end
         end
         S_LEN: begin
            buf_in[14] = len_ff[31:0];
            buf_in[15] = len_ff[63:32];
            state_in   = S_LOAD;
            after_in   = NXT_OUT;
         end
         S_LOAD: begin
            work_in  = chain_ff;
            km_in    = round_const(6'd0) + buf_ff[msg_index(6'd0)];
            rnd_in   = 6'd0;
            state_in = S_ROUND;
         end
         S_ROUND: begin
            work_in = round_out;
            km_in   = round_const(rnd_next) + buf_ff[msg_index(rnd_next)];
            rnd_in  = rnd_next;
            if (rnd_ff == 6'd63) begin
               state_in = S_ADD;
            end
         end
         S_ADD: begin
            chain_in.a = chain_ff.a + work_ff.a;
            chain_in.b = chain_ff.b + work_ff.b;
            chain_in.c = chain_ff.c + work_ff.c;
            chain_in.d = chain_ff.d + work_ff.d;
            for (int i = 0; i < 16; i++) begin
               buf_in[i] = '0;
            end
            idx_in = 2'd0;
            unique case (after_ff)
               NXT_IDLE: state_in = S_IDLE;
               NXT_PAD:  state_in = S_PAD;
               NXT_LEN:  state_in = S_LEN;
               NXT_OUT:  state_in = S_OUT;
               default:  state_in = S_IDLE;
            endcase
         end
         S_OUT: begin
            if (rsp_ready) begin
               idx_in = idx_ff + 2'd1;
               if (idx_ff == 2'd3) begin
                  chain_in = '{a: INIT_A, b: INIT_B, c: INIT_C, d: INIT_D};
                  len_in   = '0;
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         after_ff <= NXT_IDLE;
         chain_ff <= '{a: INIT_A, b: INIT_B, c: INIT_C, d: INIT_D};
         len_ff   <= '0;
         rnd_ff   <= '0;
         idx_ff   <= '0;
         for (int i = 0; i < 16; i++) begin
            buf_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         after_ff <= after_in;
         chain_ff <= chain_in;
         len_ff   <= len_in;
         rnd_ff   <= rnd_in;
         idx_ff   <= idx_in;
         buf_ff   <= buf_in;
      end
      work_ff <= work_in;
      km_ff   <= km_in;
   end

   // ---------------------------------------------------------------- checks
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request and response sides open at once");

   a_round_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ROUND && rnd_ff == 6'd63) |=> (state_ff == S_ADD))
      else $error("compression did not end after 64 rounds");

   a_len_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ROUND) |=> $stable(len_ff))
      else $error("bit length changed during compression");

   a_restart: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_last_word) |=>
         (len_ff == 64'd0 && chain_ff.a == INIT_A && chain_ff.d == INIT_D && req_ready))
      else $error("engine not restored after digest");

endmodule
